@@ rtl/btp_pkg.sv @@
// Package for the bearing-to-point block: angle constants and the CORDIC arctangent table.
// Depends on nothing; used by every module under rtl.
package btp_pkg;

  // Angle register width, in signed units of 1/256 degree.
  localparam int ZW = 18;

  localparam int ANG_90  = 23040;
  localparam int ANG_180 = 46080;

  localparam int TAB_LEN = 24;

  // Rounded atan(2^-i) in 1/256-degree units.
  localparam int ATAN_TAB [TAB_LEN] = '{
    11520, 6801, 3593, 1824, 916, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  localparam int DEG_FULL = 360;

endpackage

@@ rtl/btp_pre.sv @@
// Input cell of the bearing pipeline: forms the coordinate differences and folds the vector
// into the right half-plane. Depends on btp_pkg.
module btp_pre #(
  parameter int COORD_BITS = 16,
  parameter int XW = 19
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic signed [COORD_BITS-1:0] origin_x_i,
  input  logic signed [COORD_BITS-1:0] origin_y_i,
  input  logic signed [COORD_BITS-1:0] target_x_i,
  input  logic signed [COORD_BITS-1:0] target_y_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic signed [XW-1:0]         x_o,
  output logic signed [XW-1:0]         y_o,
  output logic signed [btp_pkg::ZW-1:0] z_o
);

  logic signed [COORD_BITS:0]       dx, dy;
  logic signed [XW-1:0]             dx_e, dy_e;
  logic signed [XW-1:0]             x_d, y_d, x_q, y_q;
  logic signed [btp_pkg::ZW-1:0]    z_d, z_q;
  logic                             valid_q;

  assign dx   = (COORD_BITS+1)'(origin_x_i) - (COORD_BITS+1)'(target_x_i);
  assign dy   = (COORD_BITS+1)'(origin_y_i) - (COORD_BITS+1)'(target_y_i);
  assign dx_e = XW'(dx);
  assign dy_e = XW'(dy);

  always_comb begin
    priority if (dx_e > 0) begin
      x_d = dx_e;
      y_d = dy_e;
      z_d = '0;
    end else if (dy_e > 0) begin
      x_d = dy_e;
      y_d = -dx_e;
      z_d = btp_pkg::ZW'(btp_pkg::ANG_90);
    end else if (dy_e < 0) begin
      x_d = -dy_e;
      y_d = dx_e;
      z_d = -btp_pkg::ZW'(btp_pkg::ANG_90);
    end else if (dx_e < 0) begin
      x_d = -dx_e;
      y_d = '0;
      z_d = btp_pkg::ZW'(btp_pkg::ANG_180);
    end else begin
      x_d = '0;
      y_d = '0;
      z_d = '0;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

@@ rtl/btp_cell.sv @@
// One CORDIC vectoring micro-rotation cell with its own pipeline register.
// Depends on btp_pkg for the arctangent table.
module btp_cell #(
  parameter int XW = 19,
  parameter int IDX = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [XW-1:0]          x_i,
  input  logic signed [XW-1:0]          y_i,
  input  logic signed [btp_pkg::ZW-1:0] z_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic signed [XW-1:0]          x_o,
  output logic signed [XW-1:0]          y_o,
  output logic signed [btp_pkg::ZW-1:0] z_o
);

  localparam logic signed [btp_pkg::ZW-1:0] Atan = btp_pkg::ZW'(btp_pkg::ATAN_TAB[IDX]);

  logic signed [XW-1:0]          x_sh, y_sh, x_d, y_d, x_q, y_q;
  logic signed [btp_pkg::ZW-1:0] z_d, z_q;
  logic                          valid_q;

  assign x_sh = x_i >>> IDX;
  assign y_sh = y_i >>> IDX;

  always_comb begin
    priority if (y_i == '0) begin
      x_d = x_i;
      y_d = y_i;
      z_d = z_i;
    end else if (!y_i[XW-1]) begin
      x_d = x_i + y_sh;
      y_d = y_i - x_sh;
      z_d = z_i + Atan;
    end else begin
      x_d = x_i - y_sh;
      y_d = y_i + x_sh;
      z_d = z_i - Atan;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

@@ rtl/btp_post.sv @@
// Output cell: turns the CORDIC angle into a whole-degree bearing and holds it for the
// output transfer. Depends on btp_pkg.
module btp_post (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [btp_pkg::ZW-1:0] z_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [8:0]                    bearing_o
);

  logic signed [btp_pkg::ZW-1:0] t;
  logic [btp_pkg::ZW-1:0]        mag;
  logic [btp_pkg::ZW-9:0]        whole;
  logic [btp_pkg::ZW-9:0]        wrapped;
  logic [8:0]                    bearing_d, bearing_q;
  logic                          valid_q;

  assign t       = z_i - btp_pkg::ZW'(btp_pkg::ANG_90);
  assign mag     = t[btp_pkg::ZW-1] ? btp_pkg::ZW'(-t) : btp_pkg::ZW'(t);
  assign whole   = mag[btp_pkg::ZW-1:8];
  assign wrapped = (btp_pkg::ZW-8)'(btp_pkg::DEG_FULL) - whole;

  // Truncation toward zero: a negative angle that rounds to zero degrees stays zero.
  always_comb begin
    priority if (!t[btp_pkg::ZW-1] || whole == '0) begin
      bearing_d = whole[8:0];
    end else begin
      bearing_d = wrapped[8:0];
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      bearing_q <= bearing_d;
    end
  end

  assign valid_o   = valid_q;
  assign bearing_o = bearing_q;

endmodule

@@ rtl/bearing_to_point_degrees.sv @@
// Whole-degree compass bearing from an origin to a target point. One point pair is taken
// per cycle while s_axis_tready is high; each result passes, in order, the input folding
// cell, one micro-rotation cell per CORDIC stage and the output cell. Every cell holds
// its own item, so an empty cell anywhere lets the cells above it move on while a result
// waits at the output; input ready drops only when all cells are full and the output is
// stalled. Depends on btp_pkg, btp_pre, btp_cell and btp_post.
module bearing_to_point_degrees #(
  parameter int CORDIC_STAGES = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // Fields from bit 0: origin_x, origin_y, target_x, target_y, then zero fill.
  input  logic [((4 * COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // Fields from bit 0: bearing (9 bits), then zero fill.
  output logic [15:0]            m_axis_tdata
);

  localparam int XW = COORD_BITS + 3;
  localparam int NS = CORDIC_STAGES;

  logic signed [XW-1:0]          x_w [NS+1];
  logic signed [XW-1:0]          y_w [NS+1];
  logic signed [btp_pkg::ZW-1:0] z_w [NS+1];
  logic [NS:0]                   valid_w;
  logic [NS:0]                   ready_w;
  logic                          post_ready;
  logic [8:0]                    bearing;

  btp_pre #(
    .COORD_BITS(COORD_BITS),
    .XW(XW)
  ) u_pre (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .origin_x_i(s_axis_tdata[COORD_BITS-1:0]),
    .origin_y_i(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .target_x_i(s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .target_y_i(s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .valid_o   (valid_w[0]),
    .ready_i   (ready_w[0]),
    .x_o       (x_w[0]),
    .y_o       (y_w[0]),
    .z_o       (z_w[0])
  );

  for (genvar i = 0; i < NS; i++) begin : g_cell
    btp_cell #(
      .XW(XW),
      .IDX(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_w[i]),
      .ready_o(ready_w[i]),
      .x_i    (x_w[i]),
      .y_i    (y_w[i]),
      .z_i    (z_w[i]),
      .valid_o(valid_w[i+1]),
      .ready_i(ready_w[i+1]),
      .x_o    (x_w[i+1]),
      .y_o    (y_w[i+1]),
      .z_o    (z_w[i+1])
    );
  end

  assign ready_w[NS] = post_ready;

  btp_post u_post (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_w[NS]),
    .ready_o  (post_ready),
    .z_i      (z_w[NS]),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .bearing_o(bearing)
  );

  assign m_axis_tdata = {7'd0, bearing};

  a_bearing_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (bearing < 9'd360))
    else $error("bearing out of range");

  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&valid_w) && m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while a pipeline cell is empty");

  a_empty_stays_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(|valid_w) && !(s_axis_tvalid && s_axis_tready) && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result appeared with nothing in flight");

endmodule
